// File: hdl/csp_pkg.sv
// Shared types, character codes and helpers for the colour specification parser.
package csp_pkg;

  // Character codes
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_SLASH = 8'h2f;  // '/'
  localparam logic [7:0] CH_R     = 8'h72;  // 'r'
  localparam logic [7:0] CH_G     = 8'h67;  // 'g'
  localparam logic [7:0] CH_B     = 8'h62;  // 'b'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'

  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] MAX_LEN = 5'd18;
  localparam logic [POS_W-1:0] POS_SAT = 5'd19;
  localparam logic [POS_W-1:0] PREFIX_LEN = 5'd4;

  localparam int unsigned ACC_W = 48;
  localparam int unsigned RGB_W = 24;

  // Form of the specification, decided by its first character
  typedef enum logic [1:0] {
    FORM_NONE = 2'd0,
    FORM_HASH = 2'd1,
    FORM_RGB  = 2'd2
  } form_t;

  // Hex digits per colour group
  typedef enum logic [1:0] {
    GRP_1 = 2'd0,
    GRP_2 = 2'd1,
    GRP_3 = 2'd2,
    GRP_4 = 2'd3
  } grp_t;

  // Parser state carried from one character to the next
  typedef struct packed {
    logic [POS_W-1:0] pos;
    form_t            form;
    logic [ACC_W-1:0] acc;
    logic [POS_W-1:0] slash1;
    logic [POS_W-1:0] slash2;
    logic [1:0]       slash_cnt;
    logic             err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    pos: '0, form: FORM_NONE, acc: '0, slash1: '0, slash2: '0,
    slash_cnt: '0, err: 1'b0
  };

  // Expected character of the "rgb:" prefix at positions 1 to 3
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd1: c = CH_G;
      2'd2: c = CH_B;
      2'd3: c = CH_COLON;
      default: c = CH_R;
    endcase
    return c;
  endfunction

  // Hex decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: hdl/csp_ifs.sv
// Valid/ready channel interfaces for the parser's character input and result output.
interface csp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

interface csp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [23:0] rgb_value;

  modport source (output valid, output valid_res, output rgb_value, input ready);
  modport sink   (input valid, input valid_res, input rgb_value, output ready);
endinterface

// File: hdl/csp_color.sv
// Colour assembly: picks the top byte of each of the three digit groups, or widens a lone digit.
module csp_color (
  input  logic [csp_pkg::ACC_W-1:0] acc,
  input  csp_pkg::grp_t             grp,
  input  logic                      replicate,
  output logic [csp_pkg::RGB_W-1:0] rgb
);
  import csp_pkg::*;

  // Group select; a single digit is either replicated or moved to the high nibble
  always_comb begin
    case (grp)
      GRP_1: begin
        if (replicate) begin
          rgb = {acc[11:8], acc[11:8], acc[7:4], acc[7:4], acc[3:0], acc[3:0]};
        end else begin
          rgb = {acc[11:8], 4'h0, acc[7:4], 4'h0, acc[3:0], 4'h0};
        end
      end
      GRP_2: rgb = acc[23:0];
      GRP_3: rgb = {acc[35:28], acc[23:16], acc[11:4]};
      GRP_4: rgb = {acc[47:40], acc[31:24], acc[15:8]};
      default: rgb = '0;
    endcase
  end

endmodule

// File: hdl/csp_step.sv
// One character of parsing: next state and, on the last character, the result.
module csp_step (
  input  csp_pkg::parse_state_t     cur,
  input  logic [7:0]                character,
  input  logic                      is_last,
  output csp_pkg::parse_state_t     nxt,
  output logic                      valid_res,
  output logic [csp_pkg::RGB_W-1:0] rgb_value
);
  import csp_pkg::*;

  parse_state_t     upd;
  logic [4:0]       hex;
  logic [POS_W-1:0] len;
  grp_t             grp;
  logic             replicate;
  logic             ok;
  logic [RGB_W-1:0] rgb;

  assign hex = hex_decode(character);

  // Syntax update for this character
  always_comb begin
    upd = cur;
    if (cur.pos >= MAX_LEN) begin
      upd.err = 1'b1;
    end else if (cur.pos == '0) begin
      if (character == CH_HASH) begin
        upd.form = FORM_HASH;
      end else if (character == CH_R) begin
        upd.form = FORM_RGB;
      end else begin
        upd.err = 1'b1;
      end
    end else if (cur.form == FORM_HASH) begin
      if (hex[4]) upd.acc = {cur.acc[ACC_W-5:0], hex[3:0]};
      else        upd.err = 1'b1;
    end else if (cur.form == FORM_RGB) begin
      if (cur.pos < PREFIX_LEN) begin
        if (character != prefix_char(cur.pos[1:0])) upd.err = 1'b1;
      end else if (character == CH_SLASH) begin
        if (cur.slash_cnt == 2'd0)      upd.slash1 = cur.pos;
        else if (cur.slash_cnt == 2'd1) upd.slash2 = cur.pos;
        if (cur.slash_cnt != 2'd3)      upd.slash_cnt = cur.slash_cnt + 2'd1;
      end else begin
        if (hex[4]) upd.acc = {cur.acc[ACC_W-5:0], hex[3:0]};
        else        upd.err = 1'b1;
      end
    end
    upd.pos = (cur.pos < POS_SAT) ? cur.pos + 5'd1 : POS_SAT;
  end

  // Length and slash check on the completed text
  assign len = upd.pos;
  always_comb begin
    ok        = 1'b0;
    grp       = GRP_1;
    replicate = 1'b0;
    if (!upd.err) begin
      if (upd.form == FORM_HASH) begin
        case (len)
          5'd4:  begin ok = 1'b1; grp = GRP_1; end
          5'd7:  begin ok = 1'b1; grp = GRP_2; end
          5'd10: begin ok = 1'b1; grp = GRP_3; end
          5'd13: begin ok = 1'b1; grp = GRP_4; end
          default: ok = 1'b0;
        endcase
      end else if (upd.form == FORM_RGB) begin
        replicate = 1'b1;
        case (len)
          5'd9:  begin ok = upd.slash1 == 5'd5 && upd.slash2 == 5'd7;  grp = GRP_1; end
          5'd12: begin ok = upd.slash1 == 5'd6 && upd.slash2 == 5'd9;  grp = GRP_2; end
          5'd15: begin ok = upd.slash1 == 5'd7 && upd.slash2 == 5'd11; grp = GRP_3; end
          5'd18: begin ok = upd.slash1 == 5'd8 && upd.slash2 == 5'd13; grp = GRP_4; end
          default: ok = 1'b0;
        endcase
        ok = ok && (upd.slash_cnt == 2'd2);
      end
    end
  end

  csp_color u_color (
    .acc       (upd.acc),
    .grp       (grp),
    .replicate (replicate),
    .rgb       (rgb)
  );

  assign valid_res = ok;
  assign rgb_value = ok ? rgb : '0;
  // Back to reset state once a specification ends
  assign nxt = is_last ? PARSE_RESET : upd;

endmodule

// File: hdl/color_spec_text_parser.sv
// Top level: colour specification parser with input and result registers.
// Takes one character per cycle on feed; an item can be accepted on every cycle as long as
// results are taken. The last character of a text waits in the input register while the parse
// step runs, and the result register loads the result once that character moves on.
// A stall on result holds back feed only once a last character is waiting in the input
// register and the result register is full.
module color_spec_text_parser (
  input logic     clk,
  input logic     rst,
  csp_in_if.sink  feed,
  csp_out_if.source result
);
  import csp_pkg::*;

  logic             in_valid;
  logic [7:0]       in_char;
  logic             in_last;
  parse_state_t     state;
  parse_state_t     state_next;
  logic             step_valid_res;
  logic [RGB_W-1:0] step_rgb;
  logic             out_valid;
  logic             out_valid_res;
  logic [RGB_W-1:0] out_rgb;
  logic             advance;

  // The held character moves on unless it ends a text and the result slot is busy
  assign advance    = in_valid && (!in_last || !out_valid || result.ready);
  assign feed.ready = !in_valid || advance;

  csp_step u_step (
    .cur       (state),
    .character (in_char),
    .is_last   (in_last),
    .nxt       (state_next),
    .valid_res (step_valid_res),
    .rgb_value (step_rgb)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (feed.ready) begin
      in_valid <= feed.valid;
    end
    if (feed.ready && feed.valid) begin
      in_char <= feed.character;
      in_last <= feed.is_last;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_last) begin
      out_valid_res <= step_valid_res;
      out_rgb       <= step_rgb;
    end
  end

  assign result.valid     = out_valid;
  assign result.valid_res = out_valid_res;
  assign result.rgb_value = out_rgb;

endmodule

// File: hdl/csp_checker.sv
// Port-level checks for the colour specification parser, bound to the top level.
module csp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [23:0] out_rgb
);

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res) && $stable(out_rgb))
    else $error("result changed while stalled");

  // A rejected text carries a zero colour
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_valid_res |-> out_rgb == 24'd0)
    else $error("invalid result with nonzero colour");

  // Nothing is pending straight after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind color_spec_text_parser csp_checker u_csp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (feed.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_valid_res (result.valid_res),
  .out_rgb       (result.rgb_value)
);

// File: test/color_spec_text_parser_test.sv
// Testbench for the colour specification parser: directed and random texts against a local model.
module color_spec_text_parser_test;
  import csp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 580;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic             valid_res;
    logic [RGB_W-1:0] rgb_value;
  } colour_result_t;

  logic clk;
  logic rst;

  csp_in_if  feed_if ();
  csp_out_if result_if ();

  color_spec_text_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_if),
    .result (result_if)
  );

  // Local parser state, mirrors what the block carries between characters
  logic [POS_W-1:0] trk_pos;
  form_t            trk_form;
  logic [ACC_W-1:0] trk_acc;
  logic [POS_W-1:0] trk_slash1;
  logic [POS_W-1:0] trk_slash2;
  logic [1:0]       trk_slashes;
  logic             trk_err;

  colour_result_t colour_queue[$];

  int    errors = 0;
  int    cycle_count = 0;
  int    sent_chars = 0;
  int    burst_left = 0;
  int    hold_left = 0;
  int    run_left = 0;
  logic  run_level = 1'b1;
  logic  hold_start;
  bit    hold_done = 1'b0;
  string hex_chars = "0123456789abcdefABCDEF";

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("color_spec_text_parser: mismatch");
      $finish;
    end
  end

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Top 8 bits of each of three groups of g digits; a lone digit is widened
  function automatic logic [RGB_W-1:0] pack_colour(input logic [ACC_W-1:0] acc, input int g,
                                                   input bit replicate);
    logic [15:0]      grp;
    logic [7:0]       chan;
    logic [RGB_W-1:0] colour;
    int               bits;
    bits = 4 * g;
    colour = '0;
    for (int i = 0; i < 3; i++) begin
      grp = 16'((acc >> (bits * (2 - i))) & ((48'd1 << bits) - 48'd1));
      if (g >= 2) chan = 8'(grp >> (bits - 8));
      else if (replicate) chan = grp[3:0] * 8'h11;
      else chan = {grp[3:0], 4'h0};
      colour = {colour[15:0], chan};
    end
    return colour;
  endfunction

  function automatic logic [7:0] random_hex();
    return hex_chars[$urandom_range(0, 21)];
  endfunction

  task automatic clear_model();
    trk_pos = '0;
    trk_form = FORM_NONE;
    trk_acc = '0;
    trk_slash1 = '0;
    trk_slash2 = '0;
    trk_slashes = '0;
    trk_err = 1'b0;
  endtask

  task automatic add_digit(input logic [7:0] c);
    int d;
    d = hex_digit(c);
    if (d < 0) trk_err = 1'b1;
    else trk_acc = {trk_acc[ACC_W-5:0], d[3:0]};
  endtask

  // Advance the model by one character; a last character queues the expected colour
  task automatic parse_char(input logic [7:0] c, input logic last);
    int             pos;
    int             len;
    int             n;
    colour_result_t res;
    pos = trk_pos;
    if (pos >= MAX_LEN) begin
      trk_err = 1'b1;
    end else if (pos == 0) begin
      if (c == CH_HASH) trk_form = FORM_HASH;
      else if (c == CH_R) trk_form = FORM_RGB;
      else trk_err = 1'b1;
    end else if (trk_form == FORM_HASH) begin
      add_digit(c);
    end else if (trk_form == FORM_RGB) begin
      if (pos < PREFIX_LEN) begin
        case (pos)
          1: if (c != CH_G) trk_err = 1'b1;
          2: if (c != CH_B) trk_err = 1'b1;
          default: if (c != CH_COLON) trk_err = 1'b1;
        endcase
      end else if (c == CH_SLASH) begin
        if (trk_slashes == 2'd0) trk_slash1 = trk_pos;
        else if (trk_slashes == 2'd1) trk_slash2 = trk_pos;
        if (trk_slashes != 2'd3) trk_slashes++;
      end else begin
        add_digit(c);
      end
    end
    if (trk_pos < POS_SAT) trk_pos = trk_pos + 5'd1;

    if (last) begin
      len = trk_pos;
      res = '0;
      if (!trk_err && len <= MAX_LEN) begin
        if (trk_form == FORM_HASH) begin
          if (len == 4 || len == 7 || len == 10 || len == 13) begin
            res.valid_res = 1'b1;
            res.rgb_value = pack_colour(trk_acc, (len - 1) / 3, 1'b0);
          end
        end else if (trk_form == FORM_RGB) begin
          if (len == 9 || len == 12 || len == 15 || len == 18) begin
            n = (len - 6) / 3;
            if (trk_slashes == 2'd2 && trk_slash1 == 4 + n && trk_slash2 == 5 + 2 * n) begin
              res.valid_res = 1'b1;
              res.rgb_value = pack_colour(trk_acc, n, 1'b1);
            end
          end
        end
      end
      colour_queue = {colour_queue, res};
      clear_model();
    end
  endtask

  // Track every accepted character
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else if (feed_if.valid && feed_if.ready) begin
      parse_char(feed_if.character, feed_if.is_last);
    end
  end

  // Compare each accepted result with the oldest expected colour
  always @(posedge clk) begin : check_results
    colour_result_t exp_res;
    if (!rst && result_if.valid && result_if.ready) begin
      if (colour_queue.size() == 0) begin
        $display("%0t: unexpected result valid_res %0b rgb_value %06h", $time,
                 result_if.valid_res, result_if.rgb_value);
        errors++;
      end else begin
        exp_res = colour_queue[0];
        colour_queue.delete(0);
        if (result_if.valid_res !== exp_res.valid_res) begin
          $display("%0t: valid_res expected %0b got %0b", $time, exp_res.valid_res,
                   result_if.valid_res);
          errors++;
        end
        if (result_if.rgb_value !== exp_res.rgb_value) begin
          $display("%0t: rgb_value expected %06h got %06h", $time, exp_res.rgb_value,
                   result_if.rgb_value);
          errors++;
        end
      end
    end
  end

  // Result side: runs of ready and stalls, long open stretches, and an on-demand hold-off
  always @(posedge clk) begin : receiver_pattern
    int pick;
    if (hold_start && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          run_level = 1'b1;
          run_left = $urandom_range(30, 60);
        end else if (pick < 7) begin
          run_level = 1'b1;
          run_left = $urandom_range(1, 8);
        end else begin
          run_level = 1'b0;
          run_left = $urandom_range(1, 5);
        end
      end
      run_left--;
      result_if.ready <= run_level;
    end
  end

  // Offer one character and wait until it is taken; gaps fall between bursts
  task automatic send_char(input logic [7:0] c, input logic last);
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        feed_if.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
    feed_if.valid <= 1'b1;
    feed_if.character <= c;
    feed_if.is_last <= last;
    @(posedge clk);
    while (!feed_if.ready) @(posedge clk);
    burst_left--;
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
  endtask

  // Well-formed '#' texts at every group size, digits of both cases
  task automatic test_hash_forms();
    send_text("#fff");
    send_text("#000000");
    send_text("#123456789");
    send_text("#FfFfFfFfFfFf");
    send_text("#aB0");
  endtask

  // Well-formed "rgb:" texts at every group size, including the full 18 characters
  task automatic test_rgb_forms();
    send_text("rgb:f/0/a");
    send_text("rgb:12/34/56");
    send_text("rgb:abc/DEF/012");
    send_text("rgb:ffff/0000/8080");
  endtask

  // Signs, spaces, 0x prefix, NUL and letters past f
  task automatic test_bad_chars();
    send_text("#12 ");
    send_text("#+1f");
    send_text("#0x1");
    send_char(CH_HASH, 1'b0);
    send_char(8'h00, 1'b0);
    send_char("f", 1'b0);
    send_char("f", 1'b1);
    send_text("rgb:1/2/G");
  endtask

  // Texts past the 18-character limit, and 18 characters of the wrong shape
  task automatic test_long_text();
    for (int i = 0; i < 19; i++) send_char(i == 0 ? CH_HASH : random_hex(), i == 18);
    for (int i = 0; i < 30; i++) send_char(i == 0 ? CH_R : random_hex(), i == 29);
    for (int i = 0; i < 18; i++) send_char(i == 0 ? CH_HASH : random_hex(), i == 17);
  endtask

  // Wrong first character, wrong case or character in the prefix, lone opening characters
  task automatic test_bad_start();
    send_text("Rgb:1/2/3");
    send_text("x12");
    send_text("rGb:1/2/3");
    send_text("rgb;1/2/3");
    send_text("#");
    send_text("r");
  endtask

  // Slashes in the wrong places or in the wrong number
  task automatic test_slash_placement();
    send_text("rgb:12/3/456");
    send_text("rgb:1/2/3/45");
    send_text("rgb:1//23");
    send_text("rgb:/1/2/3");
    send_text("rgb:123/456");
  endtask

  // Digit counts that fit no form
  task automatic test_wrong_length();
    send_text("#12345");
    send_text("#12");
    send_text("#123456789012345");
    send_text("rgb:1/2/34");
  endtask

  // Mostly well-formed texts with random digits, some broken, the rest noise
  task automatic test_random_texts();
    logic [7:0] txt[$];
    int         kind;
    int         g;
    int         at;
    int         target;
    target = sent_chars + RANDOM_CHARS;
    while (sent_chars < target) begin
      txt = {};
      kind = $urandom_range(0, 9);
      g = $urandom_range(1, 4);
      if (kind < 4) begin
        txt = {txt, CH_HASH};
        repeat (3 * g) txt = {txt, random_hex()};
      end else if (kind < 7) begin
        txt = {txt, CH_R, CH_G, CH_B, CH_COLON};
        for (int k = 0; k < 3; k++) begin
          if (k > 0) txt = {txt, CH_SLASH};
          repeat (g) txt = {txt, random_hex()};
        end
      end else if (kind == 7) begin
        // prefix then a random mix of digits and slashes
        txt = {txt, CH_R, CH_G, CH_B, CH_COLON};
        repeat ($urandom_range(3, 14)) begin
          txt = {txt, ($urandom_range(0, 3) == 0) ? CH_SLASH : random_hex()};
        end
      end else begin
        // raw bytes, sometimes behind a valid opening character
        if (kind == 8) txt = {txt, $urandom_range(0, 1) ? CH_HASH : CH_R};
        repeat ($urandom_range(1, 24)) txt = {txt, 8'($urandom_range(0, 255))};
      end
      // break a fifth of the well-formed texts
      if (kind < 7 && $urandom_range(0, 4) == 0) begin
        at = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: txt[at] = 8'($urandom_range(0, 255));
          1: txt.delete(at);
          default: txt.insert(at, $urandom_range(0, 1) ? CH_SLASH : random_hex());
        endcase
      end
      if (txt.size() == 0) txt = {txt, CH_HASH};
      send_bytes(txt);
    end
  endtask

  // Hold the result side off while short texts keep arriving, so the input stalls
  task automatic test_backpressure();
    logic [7:0] txt[$];
    hold_start <= 1'b1;
    repeat (15) begin
      txt = {};
      txt = {txt, CH_HASH};
      repeat (3) txt = {txt, random_hex()};
      send_bytes(txt);
    end
  endtask

  // Sequence
  initial begin
    rst = 1'b1;
    hold_start = 1'b0;
    feed_if.valid = 1'b0;
    feed_if.character = '0;
    feed_if.is_last = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_hash_forms();
    test_rgb_forms();
    test_bad_chars();
    test_long_text();
    test_bad_start();
    test_slash_placement();
    test_wrong_length();
    test_backpressure();
    test_random_texts();
    feed_if.valid <= 1'b0;

    @(posedge clk);
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("color_spec_text_parser: match");
    end else begin
      $display("color_spec_text_parser: mismatch");
    end
    $finish;
  end

endmodule
